>>> hw/rtl/rmq_pkg.sv
// Package for the rotation matrix to quaternion converter.
// Pipeline word, result type, case codes and the cyclic index helper.
// No dependencies.
package rmq_pkg;

  localparam int DataW  = 16;
  localparam int RootW  = 15;  // floor root of a 29-bit value
  localparam int MagW   = 17;  // magnitude of an entry sum or difference
  localparam int RemW   = 31;
  localparam int ArgFrac = 12;

  localparam logic [1:0] CASE_TRACE = 2'd0;
  localparam logic [1:0] CASE_X     = 2'd1;
  localparam logic [1:0] CASE_Y     = 2'd2;
  localparam logic [1:0] CASE_Z     = 2'd3;

  typedef struct packed {
    logic [RemW-1:0]            rem;   // root radicand remainder
    logic [RootW-1:0]           root;
    logic [2:0][MagW-1:0]       mag;
    logic [2:0]                 neg;
    logic [2:0][RemW-1:0]       drem;  // divider remainders
    logic [2:0][RootW-1:0]      quot;
    logic [2:0]                 ovf;
    logic [1:0]                 cs;
    logic                       deg;
  } pipe_t;

  typedef struct packed {
    logic signed [DataW-1:0] q_w;
    logic signed [DataW-1:0] q_x;
    logic signed [DataW-1:0] q_y;
    logic signed [DataW-1:0] q_z;
    logic [1:0]              case_taken;
    logic                    degenerate;
  } res_t;

  function automatic logic [1:0] next_idx(input logic [1:0] i);
    case (i)
      2'd0:    next_idx = 2'd1;
      2'd1:    next_idx = 2'd2;
      default: next_idx = 2'd0;
    endcase
  endfunction

endpackage

>>> hw/rtl/rmq_matrix_if.sv
// Matrix input channel: valid/ready plus nine Q2.14 entries.
// Depends on rmq_pkg.
interface rmq_matrix_if;
  logic valid;
  logic ready;
  logic signed [rmq_pkg::DataW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

>>> hw/rtl/rmq_quat_if.sv
// Quaternion output channel: valid/ready plus result fields.
// Depends on rmq_pkg.
interface rmq_quat_if;
  logic valid;
  logic ready;
  logic signed [rmq_pkg::DataW-1:0] q_w, q_x, q_y, q_z;
  logic [1:0] case_taken;
  logic       degenerate;
  modport source (output valid, q_w, q_x, q_y, q_z, case_taken, degenerate,
                  input ready);
  modport sink (input valid, q_w, q_x, q_y, q_z, case_taken, degenerate,
                output ready);
endinterface

>>> hw/rtl/rmq_front.sv
// Front stage: trace test, pivot choice, root argument and off-diagonal pairs.
// Depends on rmq_pkg.
module rmq_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             vld_i,
  input  logic signed [rmq_pkg::DataW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output logic                             vld_o,
  output rmq_pkg::pipe_t                   st_o
);

  rmq_pkg::pipe_t st_next;

  always_comb begin : calc
    logic signed [rmq_pkg::DataW-1:0] m [3][3];
    logic signed [17:0] trace;
    logic signed [18:0] arg;
    logic signed [17:0] d [3];
    logic [1:0] i, j, k;
    m[0][0] = m00; m[0][1] = m01; m[0][2] = m02;
    m[1][0] = m10; m[1][1] = m11; m[1][2] = m12;
    m[2][0] = m20; m[2][1] = m21; m[2][2] = m22;
    trace = 18'(m00) + 18'(m11) + 18'(m22);
    st_next = '0;
    i = 2'd0;
    if (m[1][1] > m[0][0]) i = 2'd1;
    if (m[2][2] > m[i][i]) i = 2'd2;
    j = rmq_pkg::next_idx(i);
    k = rmq_pkg::next_idx(j);
    if (trace > 18'sd0) begin
      arg = 19'(trace) + 19'sd16384;
      d[0] = 18'(m12) - 18'(m21);
      d[1] = 18'(m20) - 18'(m02);
      d[2] = 18'(m01) - 18'(m10);
      st_next.cs = rmq_pkg::CASE_TRACE;
    end else begin
      arg = 19'(m[i][i]) - 19'(m[j][j]) - 19'(m[k][k]) + 19'sd16384;
      d[0] = 18'(m[j][k]) - 18'(m[k][j]);
      d[1] = 18'(m[i][j]) + 18'(m[j][i]);
      d[2] = 18'(m[i][k]) + 18'(m[k][i]);
      st_next.cs = i + 2'd1;
    end
    if (arg <= 19'sd0) begin
      arg = 19'sd1;
      st_next.deg = 1'b1;
    end
    st_next.rem = {2'b0, arg[16:0], {rmq_pkg::ArgFrac{1'b0}}};
    for (int c = 0; c < 3; c++) begin
      st_next.neg[c] = d[c][17];
      st_next.mag[c] = d[c][17] ? 17'(-d[c]) : d[c][16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) st_o <= st_next;
  end

endmodule

>>> hw/rtl/rmq_sqrt.sv
// Square root pipeline: one result bit per register stage, floor root.
// Depends on rmq_pkg.
module rmq_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vld_i,
  input  rmq_pkg::pipe_t st_i,
  output logic           vld_o,
  output rmq_pkg::pipe_t st_o
);

  localparam int N = rmq_pkg::RootW;

  rmq_pkg::pipe_t st [N+1];
  logic           vld [N+1];

  assign st[0]  = st_i;
  assign vld[0] = vld_i;

  for (genvar g = 0; g < N; g++) begin : g_step
    localparam int B = N - 1 - g;
    rmq_pkg::pipe_t nx;
    logic [rmq_pkg::RemW-1:0] t;

    always_comb begin
      nx = st[g];
      // rem holds v - root^2; try adding bit B to root
      t = ({{(rmq_pkg::RemW-N){1'b0}}, st[g].root} << (B + 1))
          + ({{(rmq_pkg::RemW-1){1'b0}}, 1'b1} << (2 * B));
      if (st[g].rem >= t) begin
        nx.rem     = st[g].rem - t;
        nx.root[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) st[g+1] <= nx;
    end
  end

  assign st_o  = st[N];
  assign vld_o = vld[N];

endmodule

>>> hw/rtl/rmq_div.sv
// Rounded divider pipeline for the three pair components: one setup stage,
// then one quotient bit per stage. Depends on rmq_pkg.
module rmq_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vld_i,
  input  rmq_pkg::pipe_t st_i,
  output logic           vld_o,
  output rmq_pkg::pipe_t st_o
);

  localparam int N = rmq_pkg::RootW;
  localparam int W = rmq_pkg::RemW;

  rmq_pkg::pipe_t st [N+2];
  logic           vld [N+2];
  rmq_pkg::pipe_t prep;

  assign st[0]  = st_i;
  assign vld[0] = vld_i;

  // numerator = mag*4096 + h/2; quotient saturates when it reaches 2^15
  always_comb begin : setup
    logic [W-1:0] h;
    logic [W-1:0] num;
    prep = st[0];
    h = {{(W-N){1'b0}}, st[0].root};
    for (int c = 0; c < 3; c++) begin
      num = {2'b0, st[0].mag[c], {rmq_pkg::ArgFrac{1'b0}}}
            + {{(W-N+1){1'b0}}, st[0].root[N-1:1]};
      prep.drem[c] = num;
      prep.ovf[c]  = num >= (h << N);
      prep.quot[c] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[1] <= 1'b0;
    end else if (en) begin
      vld[1] <= vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) st[1] <= prep;
  end

  for (genvar g = 0; g < N; g++) begin : g_step
    localparam int B = N - 1 - g;
    rmq_pkg::pipe_t nx;
    logic [W-1:0] t;

    always_comb begin
      nx = st[g+1];
      t  = {{(W-N){1'b0}}, st[g+1].root} << B;
      for (int c = 0; c < 3; c++) begin
        if (st[g+1].drem[c] >= t) begin
          nx.drem[c]    = st[g+1].drem[c] - t;
          nx.quot[c][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+2] <= 1'b0;
      end else if (en) begin
        vld[g+2] <= vld[g+1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) st[g+2] <= nx;
    end
  end

  assign st_o  = st[N+1];
  assign vld_o = vld[N+1];

endmodule

>>> hw/rtl/rmq_back.sv
// Output stage: sign, saturation and placement of components by case code.
// Depends on rmq_pkg.
module rmq_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vld_i,
  input  rmq_pkg::pipe_t st_i,
  output logic           vld_o,
  output rmq_pkg::res_t  res
);

  rmq_pkg::res_t res_next;

  always_comb begin : place
    logic signed [rmq_pkg::DataW-1:0] c [3];
    logic signed [rmq_pkg::DataW-1:0] r;
    for (int n = 0; n < 3; n++) begin
      if (st_i.neg[n]) begin
        c[n] = st_i.ovf[n] ? -16'sd32768 : -$signed({1'b0, st_i.quot[n]});
      end else begin
        c[n] = st_i.ovf[n] ? 16'sd32767 : $signed({1'b0, st_i.quot[n]});
      end
    end
    r = $signed({1'b0, st_i.root});
    res_next.case_taken = st_i.cs;
    res_next.degenerate = st_i.deg;
    case (st_i.cs)
      rmq_pkg::CASE_TRACE: begin
        res_next.q_w = r;    res_next.q_x = c[0];
        res_next.q_y = c[1]; res_next.q_z = c[2];
      end
      rmq_pkg::CASE_X: begin
        res_next.q_x = r;    res_next.q_w = c[0];
        res_next.q_y = c[1]; res_next.q_z = c[2];
      end
      rmq_pkg::CASE_Y: begin
        res_next.q_y = r;    res_next.q_w = c[0];
        res_next.q_z = c[1]; res_next.q_x = c[2];
      end
      default: begin
        res_next.q_z = r;    res_next.q_w = c[0];
        res_next.q_x = c[1]; res_next.q_y = c[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) res <= res_next;
  end

endmodule

>>> hw/rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion, Q2.14 in and out. One matrix is taken
// every clock cycle while the output is not held off; each result passes the
// front stage, the 15-stage square root, the 16-stage rounded divider and the
// output stage in turn. When the output is held off the whole
// pipeline freezes in place, so nothing is dropped or repeated.
// Depends on rmq_pkg, rmq_matrix_if, rmq_quat_if and the rmq_* stage modules.
module rotation_matrix_to_quaternion (
  input  logic       clk,
  input  logic       rst,
  rmq_matrix_if.sink matrix,
  rmq_quat_if.source quat
);

  logic           en;
  logic           v1, v2, v3;
  rmq_pkg::pipe_t s1, s2, s3;
  rmq_pkg::res_t  res;

  assign en           = !quat.valid || quat.ready;
  assign matrix.ready = en;

  rmq_front u_front (
    .clk, .rst, .en,
    .vld_i (matrix.valid),
    .m00 (matrix.m00), .m01 (matrix.m01), .m02 (matrix.m02),
    .m10 (matrix.m10), .m11 (matrix.m11), .m12 (matrix.m12),
    .m20 (matrix.m20), .m21 (matrix.m21), .m22 (matrix.m22),
    .vld_o (v1), .st_o (s1)
  );

  rmq_sqrt u_sqrt (.clk, .rst, .en, .vld_i (v1), .st_i (s1), .vld_o (v2), .st_o (s2));
  rmq_div  u_div  (.clk, .rst, .en, .vld_i (v2), .st_i (s2), .vld_o (v3), .st_o (s3));

  rmq_back u_back (.clk, .rst, .en, .vld_i (v3), .st_i (s3), .vld_o (quat.valid), .res);

  assign quat.q_w        = res.q_w;
  assign quat.q_x        = res.q_x;
  assign quat.q_y        = res.q_y;
  assign quat.q_z        = res.q_z;
  assign quat.case_taken = res.case_taken;
  assign quat.degenerate = res.degenerate;

  a_deg_off_trace: assert property (@(posedge clk) disable iff (rst)
    quat.valid && quat.degenerate |-> quat.case_taken != rmq_pkg::CASE_TRACE)
    else $error("degenerate flag on trace path");

  a_trace_root: assert property (@(posedge clk) disable iff (rst)
    quat.valid && quat.case_taken == rmq_pkg::CASE_TRACE |-> quat.q_w >= 16'sd64)
    else $error("trace path root below minimum");

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    matrix.ready == (!quat.valid || quat.ready))
    else $error("input ready does not follow output stall");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !quat.valid)
    else $error("result valid right after reset");

endmodule

>>> test/tb_top.sv
// Testbench for rotation_matrix_to_quaternion: drives matrices, predicts each
// quaternion with a bit-exact fixed-point model and checks every result transfer.
// Depends on rmq_pkg, rmq_matrix_if, rmq_quat_if and the RTL.
module tb_top;

  typedef struct {
    logic signed [15:0] m [3][3];
  } mat_t;

  logic clk;
  logic rst;
  bit   src_steady;
  bit   snk_steady;
  int   mismatches;
  int   idle_cycles;
  bit   timed_out;
  rmq_pkg::res_t quat_expected [$];

  rmq_matrix_if matrix ();
  rmq_quat_if   quat ();

  rotation_matrix_to_quaternion u_dut (
    .clk    (clk),
    .rst    (rst),
    .matrix (matrix.sink),
    .quat   (quat.source)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // round to nearest, ties away from zero, then saturate
  function automatic logic signed [15:0] scaled_quot(input longint d, input longint h);
    longint mag;
    longint q;
    mag = (d < 0) ? -d : d;
    q = ((mag << 12) + (h >> 1)) / h;
    return clamp16((d < 0) ? -q : q);
  endfunction

  function automatic rmq_pkg::res_t quat_of(input mat_t a);
    rmq_pkg::res_t r;
    longint m [3][3];
    longint q [4];
    longint arg;
    longint h;
    int i, j, k;
    for (int rr = 0; rr < 3; rr++)
      for (int cc = 0; cc < 3; cc++)
        m[rr][cc] = a.m[rr][cc];
    r.degenerate = 1'b0;
    arg = m[0][0] + m[1][1] + m[2][2];
    if (arg > 0) begin
      h = int_sqrt((arg + 16384) << 12);
      q[0] = h;
      r.q_w = clamp16(h);
      r.q_x = scaled_quot(m[1][2] - m[2][1], h);
      r.q_y = scaled_quot(m[2][0] - m[0][2], h);
      r.q_z = scaled_quot(m[0][1] - m[1][0], h);
      r.case_taken = rmq_pkg::CASE_TRACE;
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      arg = m[i][i] - m[j][j] - m[k][k] + 16384;
      if (arg <= 0) begin
        arg = 1;
        r.degenerate = 1'b1;
      end
      h = int_sqrt(arg << 12);
      q[1 + i] = h;
      q[0] = scaled_quot(m[j][k] - m[k][j], h);
      q[1 + j] = scaled_quot(m[i][j] + m[j][i], h);
      q[1 + k] = scaled_quot(m[i][k] + m[k][i], h);
      r.q_w = clamp16(q[0]);
      r.q_x = clamp16(q[1]);
      r.q_y = clamp16(q[2]);
      r.q_z = clamp16(q[3]);
      case (i)
        0: r.case_taken = rmq_pkg::CASE_X;
        1: r.case_taken = rmq_pkg::CASE_Y;
        default: r.case_taken = rmq_pkg::CASE_Z;
      endcase
    end
    return r;
  endfunction

  // valid stays high after a transfer until the next one or an idle cycle
  task automatic send_matrix(input mat_t a);
    while (!src_steady && $urandom_range(99) < 31) begin
      if (matrix.valid) matrix.valid <= 1'b0;
      @(posedge clk);
    end
    matrix.valid <= 1'b1;
    matrix.m00 <= a.m[0][0]; matrix.m01 <= a.m[0][1]; matrix.m02 <= a.m[0][2];
    matrix.m10 <= a.m[1][0]; matrix.m11 <= a.m[1][1]; matrix.m12 <= a.m[1][2];
    matrix.m20 <= a.m[2][0]; matrix.m21 <= a.m[2][1]; matrix.m22 <= a.m[2][2];
    do @(posedge clk); while (!matrix.ready);
    quat_expected.push_back(quat_of(a));
  endtask

  function automatic mat_t diag_matrix(input int a, input int b, input int c);
    mat_t r;
    for (int rr = 0; rr < 3; rr++)
      for (int cc = 0; cc < 3; cc++)
        r.m[rr][cc] = 16'sd0;
    r.m[0][0] = 16'(a);
    r.m[1][1] = 16'(b);
    r.m[2][2] = 16'(c);
    return r;
  endfunction

  function automatic mat_t random_matrix();
    mat_t r;
    for (int rr = 0; rr < 3; rr++)
      for (int cc = 0; cc < 3; cc++)
        r.m[rr][cc] = 16'($urandom);
    return r;
  endfunction

  // every entry uniform in [-1,1], diagonal and off-diagonal alike
  function automatic mat_t plausible_matrix();
    mat_t r;
    for (int rr = 0; rr < 3; rr++)
      for (int cc = 0; cc < 3; cc++)
        r.m[rr][cc] = 16'(int'($urandom_range(32768)) - 16384);
    return r;
  endfunction

  task automatic wait_drained();
    matrix.valid <= 1'b0;
    while (quat_expected.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    mat_t a;
    send_matrix(diag_matrix(16384, 16384, 16384));
    send_matrix(diag_matrix(16384, -16384, -16384));
    send_matrix(diag_matrix(-16384, 16384, -16384));
    send_matrix(diag_matrix(-16384, -16384, 16384));
    send_matrix(diag_matrix(0, 0, 0));
    send_matrix(diag_matrix(16384, 0, -16384));
    send_matrix(diag_matrix(5, 5, 5));
    send_matrix(diag_matrix(100, 100, -50));
    send_matrix(diag_matrix(-32768, -32768, -32768));
    send_matrix(diag_matrix(32767, 32767, 32767));
    send_matrix(diag_matrix(-20000, 10000, 10000));
    send_matrix(diag_matrix(32767, 32767, -32768));
    for (int n = 0; n < 6; n++) begin
      a = diag_matrix(-16384, -16384, -16384 + n);
      for (int rr = 0; rr < 3; rr++)
        for (int cc = 0; cc < 3; cc++)
          if (rr != cc) a.m[rr][cc] = (n % 2) ? -16'sd32768 : 16'sd32767;
      if (n >= 2) a.m[n % 3][(n + 1) % 3] = 16'sd0;
      send_matrix(a);
    end
    a = diag_matrix(16384, 16384, 16384);
    a.m[1][2] = 16'sd32767; a.m[2][1] = -16'sd32768;
    send_matrix(a);
    send_matrix(random_matrix());
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      src_steady = (n >= count / 3 && n < count / 3 + 150);
      if ($urandom_range(99) < 70) send_matrix(plausible_matrix());
      else send_matrix(random_matrix());
    end
    src_steady = 1'b0;
  endtask

  // result side: random stalls, compare each transfer with the oldest prediction
  always @(posedge clk) begin
    rmq_pkg::res_t e;
    if (rst) begin
      quat.ready <= 1'b0;
    end else begin
      quat.ready <= snk_steady || ($urandom_range(99) >= 31);
      if (quat.valid && quat.ready) begin
        if (quat_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer");
        end else begin
          e = quat_expected.pop_front();
          if (quat.q_w !== e.q_w || quat.q_x !== e.q_x || quat.q_y !== e.q_y ||
              quat.q_z !== e.q_z || quat.case_taken !== e.case_taken ||
              quat.degenerate !== e.degenerate) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %0d %0d %0d %0d c%0d d%0d got %0d %0d %0d %0d c%0d d%0d",
                       e.q_w, e.q_x, e.q_y, e.q_z, e.case_taken, e.degenerate,
                       quat.q_w, quat.q_x, quat.q_y, quat.q_z, quat.case_taken,
                       quat.degenerate);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((matrix.valid && matrix.ready) || (quat.valid && quat.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000 && !timed_out) begin
      timed_out = 1'b1;
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    matrix.valid <= 1'b0;
    {matrix.m00, matrix.m01, matrix.m02, matrix.m10, matrix.m11} <= '0;
    {matrix.m12, matrix.m20, matrix.m21, matrix.m22} <= '0;
    src_steady = 1'b0;
    snk_steady = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_random(500);
    wait_drained();
    snk_steady = 1'b1;
    test_random(200);
    snk_steady = 1'b0;
    test_random(330);
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && quat_expected.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
